### rtl/core/wsfr_pkg.sv
package wsfr_pkg;

	// Opcodes as they appear in the low nibble of the control byte
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// Frame kind codes on the result side
	localparam logic [2:0] KIND_CONT  = 3'd0;
	localparam logic [2:0] KIND_TEXT  = 3'd1;
	localparam logic [2:0] KIND_BIN   = 3'd2;
	localparam logic [2:0] KIND_CLOSE = 3'd3;
	localparam logic [2:0] KIND_PING  = 3'd4;
	localparam logic [2:0] KIND_PONG  = 3'd5;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_OPCODE = 2'd1;
	localparam logic [1:0] ERR_LIMIT  = 2'd2;

	// Length byte escapes
	localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
	localparam logic [6:0] LEN_ESC_16    = 7'd126;

	localparam int TDATA_W = 96;
	localparam int TUSER_W = 6;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        data_valid;
		logic [2:0]  frame_kind;
		logic        final_fragment;
		logic [15:0] close_status;
		logic        has_status;
		logic [63:0] payload_length;
		logic        frame_end;
		logic [1:0]  error;
	} res_t;

endpackage

### rtl/core/wsfr_parser.sv
module wsfr_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_data,
	input  logic               fire,
	input  logic [7:0]         rx_byte,
	output logic               res_push,
	output wsfr_pkg::res_t     res
);
	import wsfr_pkg::*;

	typedef enum logic [2:0] {
		PH_CTRL, PH_LEN1, PH_LENEXT, PH_MASK, PH_STATUS, PH_DATA
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [2:0]  hdr_left_q, n_hdr_left;
	logic [2:0]  kind_q, n_kind;
	logic        fin_q, n_fin;
	logic        masked_q, n_masked;
	logic [31:0] key_q, n_key;
	logic [63:0] len_q, n_len;
	logic [63:0] rem_q, n_rem;
	logic [15:0] status_q, n_status;
	logic        sflag_q, n_sflag;
	logic [1:0]  mpos_q, n_mpos;
	logic [31:0] max_payload_q;

	logic        length_chk, header_chk, payload_chk;
	logic        emit;
	logic [7:0]  e_byte;
	logic        e_valid, e_end;
	logic [1:0]  e_err;
	logic [7:0]  key_byte;
	logic [7:0]  unmasked;
	logic [6:0]  len7;
	logic        over_limit;

	// key byte at the current mask position, first key byte in the top bits
	always_comb begin
		case (mpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		unmasked = masked_q ? (rx_byte ^ key_byte) : rx_byte;
	end

	assign len7 = rx_byte[6:0];

	// next state and result for one byte
	always_comb begin
		n_phase    = phase_q;
		n_hdr_left = hdr_left_q;
		n_kind     = kind_q;
		n_fin      = fin_q;
		n_masked   = masked_q;
		n_key      = key_q;
		n_len      = len_q;
		n_rem      = rem_q;
		n_status   = status_q;
		n_sflag    = sflag_q;
		n_mpos     = mpos_q;
		length_chk = 1'b0;
		header_chk = 1'b0;
		payload_chk = 1'b0;
		emit       = 1'b0;
		e_byte     = 8'd0;
		e_valid    = 1'b0;
		e_end      = 1'b0;
		e_err      = ERR_NONE;
		over_limit = 1'b0;

		case (phase_q)
			PH_CTRL: begin
				n_status = 16'd0;
				n_sflag  = 1'b0;
				n_len    = 64'd0;
				n_rem    = 64'd0;
				n_key    = 32'd0;
				n_mpos   = 2'd0;
				n_masked = 1'b0;
				n_fin    = rx_byte[7];
				n_phase  = PH_LEN1;
				case (rx_byte[3:0])
					OP_CONT:  n_kind = KIND_CONT;
					OP_TEXT:  n_kind = KIND_TEXT;
					OP_BIN:   n_kind = KIND_BIN;
					OP_CLOSE: n_kind = KIND_CLOSE;
					OP_PING:  n_kind = KIND_PING;
					OP_PONG:  n_kind = KIND_PONG;
					default: begin
						n_kind  = KIND_CONT;
						n_fin   = 1'b0;
						n_phase = PH_CTRL;
						emit    = 1'b1;
						e_end   = 1'b1;
						e_err   = ERR_OPCODE;
					end
				endcase
			end
			PH_LEN1: begin
				n_masked = rx_byte[7];
				if (len7 <= LEN_MAX_SHORT) begin
					n_len      = {57'd0, len7};
					length_chk = 1'b1;
				end else begin
					n_len      = 64'd0;
					n_hdr_left = (len7 == LEN_ESC_16) ? 3'd1 : 3'd7;
					n_phase    = PH_LENEXT;
				end
			end
			PH_LENEXT: begin
				n_len = {len_q[55:0], rx_byte};
				if (hdr_left_q == 3'd0) length_chk = 1'b1;
				else n_hdr_left = hdr_left_q - 3'd1;
			end
			PH_MASK: begin
				n_key = {key_q[23:0], rx_byte};
				if (hdr_left_q == 3'd0) header_chk = 1'b1;
				else n_hdr_left = hdr_left_q - 3'd1;
			end
			PH_STATUS: begin
				n_status = {status_q[7:0], unmasked};
				if (masked_q) n_mpos = mpos_q + 2'd1;
				if (hdr_left_q == 3'd0) begin
					n_sflag     = 1'b1;
					payload_chk = 1'b1;
				end else begin
					n_hdr_left = hdr_left_q - 3'd1;
				end
			end
			PH_DATA: begin
				if (masked_q) n_mpos = mpos_q + 2'd1;
				emit    = 1'b1;
				e_byte  = unmasked;
				e_valid = 1'b1;
				if (rem_q <= 64'd1) begin
					n_rem   = 64'd0;
					e_end   = 1'b1;
					n_phase = PH_CTRL;
				end else begin
					n_rem = rem_q - 64'd1;
				end
			end
			default: n_phase = PH_CTRL;
		endcase

		// length complete: a key may follow
		if (length_chk) begin
			if (n_masked) begin
				n_key      = 32'd0;
				n_hdr_left = 3'd3;
				n_phase    = PH_MASK;
			end else begin
				header_chk = 1'b1;
			end
		end

		// header complete: a close frame with room carries a status first
		if (header_chk) begin
			if (n_kind == KIND_CLOSE && n_len >= 64'd2) begin
				n_len      = n_len - 64'd2;
				n_status   = 16'd0;
				n_hdr_left = 3'd1;
				n_phase    = PH_STATUS;
			end else begin
				payload_chk = 1'b1;
			end
		end

		// payload start: empty frame, limit check or data phase
		if (payload_chk) begin
			over_limit = (max_payload_q != 32'd0) &&
				((n_len[63:32] != 32'd0) || (n_len[31:0] > max_payload_q));
			if (n_len == 64'd0) begin
				n_phase = PH_CTRL;
				emit    = 1'b1;
				e_end   = 1'b1;
			end else if (over_limit) begin
				n_phase = PH_CTRL;
				emit    = 1'b1;
				e_end   = 1'b1;
				e_err   = ERR_LIMIT;
			end else begin
				n_rem   = n_len;
				n_phase = PH_DATA;
			end
		end
	end

	// result fields reflect the state after this byte
	always_comb begin
		res.data_byte      = e_byte;
		res.data_valid     = e_valid;
		res.frame_kind     = n_kind;
		res.final_fragment = n_fin;
		res.close_status   = n_sflag ? n_status : 16'd0;
		res.has_status     = n_sflag;
		res.payload_length = n_len;
		res.frame_end      = e_end;
		res.error          = e_err;
	end

	assign res_push = fire && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_CTRL;
			hdr_left_q    <= 3'd0;
			kind_q        <= 3'd0;
			fin_q         <= 1'b0;
			masked_q      <= 1'b0;
			key_q         <= 32'd0;
			len_q         <= 64'd0;
			rem_q         <= 64'd0;
			status_q      <= 16'd0;
			sflag_q       <= 1'b0;
			mpos_q        <= 2'd0;
			max_payload_q <= 32'd0;
		end else begin
			if (cfg_we) max_payload_q <= cfg_data;
			if (fire) begin
				phase_q    <= n_phase;
				hdr_left_q <= n_hdr_left;
				kind_q     <= n_kind;
				fin_q      <= n_fin;
				masked_q   <= n_masked;
				key_q      <= n_key;
				len_q      <= n_len;
				rem_q      <= n_rem;
				status_q   <= n_status;
				sflag_q    <= n_sflag;
				mpos_q     <= n_mpos;
			end
		end
	end

endmodule

### rtl/core/wsfr_out_buf.sv
module wsfr_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wsfr_pkg::res_t     push_data,
	output logic               full,
	output logic               head_valid,
	output wsfr_pkg::res_t     head_data,
	input  logic               pop_ready
);
	import wsfr_pkg::*;

	res_t head_q, skid_q;
	logic head_v_q, skid_v_q;
	logic pop;

	assign pop        = head_v_q && pop_ready;
	assign full       = skid_v_q;
	assign head_valid = head_v_q;
	assign head_data  = head_q;

	// two-entry result buffer: head drives the port, skid catches a stalled beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (!head_v_q) begin
			head_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (!head_v_q) begin
			head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

### rtl/core/websocket_frame_receiver.sv
// WebSocket frame receiver: parses one received byte per beat on s_* and emits
// one result beat on m_* for every payload byte, plus a single beat for an
// empty frame, an unknown opcode or a payload over max_payload (written on
// cfg_*, zero means no limit). Header, key and close-status bytes give no beat.
// Throughput is one byte per clock while results drain; a byte passes the input
// register, then the parser state and result register on its way out. A
// two-entry result buffer keeps input flowing for one beat while m_tready is
// low; beyond that s_tready drops until results drain.
module websocket_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [31:0]                    cfg_data,    // max_payload
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,     // rx_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wsfr_pkg::TDATA_W-1:0]   m_tdata,     // data_byte, final_fragment,
	                                                    // close_status, has_status,
	                                                    // payload_length, zero pad
	output logic [wsfr_pkg::TUSER_W-1:0]   m_tuser,     // data_valid, frame_kind, error
	output logic                           m_tlast      // frame_end
);
	import wsfr_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       buf_full;
	logic       push;
	res_t       res, head;

	assign cfg_ready = 1'b1;
	assign fire      = vld_s1 && !buf_full;
	assign s_tready  = !vld_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
	end

	wsfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.fire     (fire),
		.rx_byte  (byte_s1),
		.res_push (push),
		.res      (res)
	);

	wsfr_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (res),
		.full       (buf_full),
		.head_valid (m_tvalid),
		.head_data  (head),
		.pop_ready  (m_tready)
	);

	// pack result beat
	assign m_tdata = {6'd0, head.payload_length, head.has_status, head.close_status,
		head.final_fragment, head.data_byte};
	assign m_tuser = {head.error, head.frame_kind, head.data_valid};
	assign m_tlast = head.frame_end;

	// the skid entry is only used behind a valid head
	assert property (@(posedge clk) disable iff (!arst_n) buf_full |-> m_tvalid)
		else $error("skid entry valid without head entry");

	// a held input byte is not lost while the buffer is full
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !fire) |=> (vld_s1 && $stable(byte_s1)))
		else $error("input register dropped a stalled byte");

	// any error result closes the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[5:4] != ERR_NONE)) |-> m_tlast)
		else $error("error result without frame end");

	// a result without payload data is always the end of a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("dataless result not marked as frame end");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import wsfr_pkg::*;

	localparam logic [6:0] LEN_ESC_64  = 7'd127;
	localparam int         STALL_LIMIT = 2000;
	localparam int         HOLD_CYCLES = 80;

	typedef enum logic [2:0] {
		P_CTRL,
		P_LEN,
		P_XLEN,
		P_KEY,
		P_STAT,
		P_DATA
	} parse_phase_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [95:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	// received bytes waiting to be offered, results the parser must produce
	logic [7:0] rx_bytes_q[$];
	res_t       parsed_beats_q[$];
	int         bytes_queued = 0;

	// parser shadow state
	parse_phase_t ph        = P_CTRL;
	logic [2:0]   hdr_left  = '0;
	logic [2:0]   kind_q    = KIND_CONT;
	logic         fin_q     = 1'b0;
	logic         masked_q  = 1'b0;
	logic [31:0]  key_q     = '0;
	logic [63:0]  len_q     = '0;
	logic [63:0]  remain_q  = '0;
	logic [15:0]  stat_q    = '0;
	logic         stat_seen = 1'b0;
	logic [1:0]   key_pos   = '0;
	logic [31:0]  lim_cfg   = '0;

	// flow control between the stimulus and the two sides
	bit no_idle   = 1'b0;
	int hold_req  = 0;
	int hold_ack  = 0;
	int hold_left = 0;
	int src_gap   = 0;
	int sink_gap  = 0;
	int mismatches  = 0;
	int idle_cycles = 0;
	res_t seen_res;
	res_t want_res;

	websocket_frame_receiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial forever #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Frame parser prediction
	// ---------------------------------------------------------------
	function automatic void post_result(input logic [7:0] d, input logic v, input logic e,
	                                    input logic [1:0] err);
		res_t r;
		r.data_byte      = d;
		r.data_valid     = v;
		r.frame_kind     = kind_q;
		r.final_fragment = fin_q;
		r.close_status   = stat_seen ? stat_q : 16'd0;
		r.has_status     = stat_seen;
		r.payload_length = len_q;
		r.frame_end      = e;
		r.error          = err;
		parsed_beats_q.push_back(r);
	endfunction

	// XOR with the key byte at the running position; position only moves when masked
	function automatic logic [7:0] strip_key(input logic [7:0] b);
		logic [7:0] k;
		k = 8'd0;
		if (masked_q) begin
			k = key_q[8 * (3 - key_pos) +: 8];
			key_pos = key_pos + 2'd1;
		end
		return b ^ k;
	endfunction

	function automatic void open_payload();
		if (len_q == 64'd0) begin
			ph = P_CTRL;
			post_result(8'd0, 1'b0, 1'b1, ERR_NONE);
		end else if (lim_cfg != 32'd0 && len_q > {32'd0, lim_cfg}) begin
			ph = P_CTRL;
			post_result(8'd0, 1'b0, 1'b1, ERR_LIMIT);
		end else begin
			remain_q = len_q;
			ph = P_DATA;
		end
	endfunction

	// close frames of two bytes or more carry a status code first
	function automatic void finish_header();
		if (kind_q == KIND_CLOSE && len_q >= 64'd2) begin
			len_q    = len_q - 64'd2;
			stat_q   = '0;
			hdr_left = 3'd1;
			ph       = P_STAT;
		end else begin
			open_payload();
		end
	endfunction

	function automatic void finish_length();
		if (masked_q) begin
			key_q    = '0;
			hdr_left = 3'd3;
			ph       = P_KEY;
		end else begin
			finish_header();
		end
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b);
		logic [7:0] d;
		logic [6:0] l;
		bit known;
		case (ph)
			P_CTRL: begin
				stat_q    = '0;
				stat_seen = 1'b0;
				len_q     = '0;
				remain_q  = '0;
				key_q     = '0;
				key_pos   = '0;
				masked_q  = 1'b0;
				known     = 1'b1;
				case (b[3:0])
					OP_CONT:  kind_q = KIND_CONT;
					OP_TEXT:  kind_q = KIND_TEXT;
					OP_BIN:   kind_q = KIND_BIN;
					OP_CLOSE: kind_q = KIND_CLOSE;
					OP_PING:  kind_q = KIND_PING;
					OP_PONG:  kind_q = KIND_PONG;
					default:  known = 1'b0;
				endcase
				if (known) begin
					fin_q = b[7];
					ph    = P_LEN;
				end else begin
					kind_q = KIND_CONT;
					fin_q  = 1'b0;
					ph     = P_CTRL;
					post_result(8'd0, 1'b0, 1'b1, ERR_OPCODE);
				end
			end
			P_LEN: begin
				l = b[6:0];
				masked_q = b[7];
				if (l <= LEN_MAX_SHORT) begin
					len_q = {57'd0, l};
					finish_length();
				end else begin
					len_q    = '0;
					hdr_left = (l == LEN_ESC_16) ? 3'd1 : 3'd7;
					ph       = P_XLEN;
				end
			end
			P_XLEN: begin
				len_q = {len_q[55:0], b};
				if (hdr_left == 3'd0) finish_length();
				else hdr_left = hdr_left - 3'd1;
			end
			P_KEY: begin
				key_q = {key_q[23:0], b};
				if (hdr_left == 3'd0) finish_header();
				else hdr_left = hdr_left - 3'd1;
			end
			P_STAT: begin
				stat_q = {stat_q[7:0], strip_key(b)};
				if (hdr_left == 3'd0) begin
					stat_seen = 1'b1;
					open_payload();
				end else begin
					hdr_left = hdr_left - 3'd1;
				end
			end
			P_DATA: begin
				d = strip_key(b);
				if (remain_q <= 64'd1) begin
					remain_q = '0;
					ph = P_CTRL;
					post_result(d, 1'b1, 1'b1, ERR_NONE);
				end else begin
					remain_q = remain_q - 64'd1;
					post_result(d, 1'b1, 1'b0, ERR_NONE);
				end
			end
			default: ph = P_CTRL;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Input side: offer queued bytes, predict on every accepted beat
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap  <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (rx_bytes_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 9) == 0) begin
					src_gap  <= $urandom_range(0, 8);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= rx_bytes_q.pop_front();
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output side: random stalls, long hold on request, beat checks
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			sink_gap  <= 0;
			hold_left <= 0;
			hold_ack  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_res.data_byte      = m_tdata[7:0];
				seen_res.final_fragment = m_tdata[8];
				seen_res.close_status   = m_tdata[24:9];
				seen_res.has_status     = m_tdata[25];
				seen_res.payload_length = m_tdata[89:26];
				seen_res.data_valid     = m_tuser[0];
				seen_res.frame_kind     = m_tuser[3:1];
				seen_res.error          = m_tuser[5:4];
				seen_res.frame_end      = m_tlast;
				if (parsed_beats_q.size() == 0) begin
					$error("result beat with no expectation pending");
					mismatches++;
				end else begin
					want_res = parsed_beats_q.pop_front();
					if (seen_res.data_byte !== want_res.data_byte) begin
						$error("data_byte: expected %h, got %h",
							want_res.data_byte, seen_res.data_byte);
						mismatches++;
					end
					if (seen_res.data_valid !== want_res.data_valid) begin
						$error("data_valid: expected %b, got %b",
							want_res.data_valid, seen_res.data_valid);
						mismatches++;
					end
					if (seen_res.frame_kind !== want_res.frame_kind) begin
						$error("frame_kind: expected %0d, got %0d",
							want_res.frame_kind, seen_res.frame_kind);
						mismatches++;
					end
					if (seen_res.final_fragment !== want_res.final_fragment) begin
						$error("final_fragment: expected %b, got %b",
							want_res.final_fragment, seen_res.final_fragment);
						mismatches++;
					end
					if (seen_res.close_status !== want_res.close_status) begin
						$error("close_status: expected %h, got %h",
							want_res.close_status, seen_res.close_status);
						mismatches++;
					end
					if (seen_res.has_status !== want_res.has_status) begin
						$error("has_status: expected %b, got %b",
							want_res.has_status, seen_res.has_status);
						mismatches++;
					end
					if (seen_res.payload_length !== want_res.payload_length) begin
						$error("payload_length: expected %h, got %h",
							want_res.payload_length, seen_res.payload_length);
						mismatches++;
					end
					if (seen_res.frame_end !== want_res.frame_end) begin
						$error("frame_end: expected %b, got %b",
							want_res.frame_end, seen_res.frame_end);
						mismatches++;
					end
					if (seen_res.error !== want_res.error) begin
						$error("error: expected %0d, got %0d",
							want_res.error, seen_res.error);
						mismatches++;
					end
				end
			end
			if (hold_ack != hold_req) begin
				hold_ack  <= hold_req;
				hold_left <= HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				sink_gap <= $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// no beat on any channel for too long means the block hung
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic put_byte(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_queued++;
	endtask

	task automatic set_limit(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		lim_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	// wait until every byte is taken and every result seen, then let the pipe settle
	task automatic drain(input int settle);
		do @(negedge clk);
		while (rx_bytes_q.size() != 0 || s_tvalid || parsed_beats_q.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	// one frame; body bytes are sent only where the parser will want them
	task automatic queue_frame(input logic [3:0] op, input logic fin, input logic mk,
	                           input int form, input logic [63:0] len);
		logic [2:0]  rsv;
		logic [31:0] key;
		logic [63:0] body;
		logic [7:0]  rb;
		int n_stat;
		int n_body;
		int i;
		bit known;
		rsv = 3'($urandom_range(0, 7));
		key = $urandom;
		case (op)
			OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: known = 1'b1;
			default: known = 1'b0;
		endcase
		put_byte({fin, rsv, op});
		if (known) begin
			if (form == 0 && len > 64'd125) form = 1;
			if (form == 1 && len > 64'd65535) form = 2;
			case (form)
				0: put_byte({mk, len[6:0]});
				1: begin
					put_byte({mk, LEN_ESC_16});
					put_byte(len[15:8]);
					put_byte(len[7:0]);
				end
				default: begin
					put_byte({mk, LEN_ESC_64});
					for (i = 7; i >= 0; i--) put_byte(len[8 * i +: 8]);
				end
			endcase
			if (mk)
				for (i = 3; i >= 0; i--) put_byte(key[8 * i +: 8]);
			n_stat = (op == OP_CLOSE && len >= 64'd2) ? 2 : 0;
			body = len - n_stat;
			if (lim_cfg != 32'd0 && body > {32'd0, lim_cfg}) body = '0;
			n_body = body[31:0];
			for (i = 0; i < n_stat + n_body; i++) begin
				rb = 8'($urandom);
				put_byte(rb);
			end
		end
	endtask

	task automatic queue_random_frame();
		logic [3:0]  op;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [63:0] len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) op = 4'($urandom_range(3, 7));
		else if (r < 8) op = 4'($urandom_range(11, 15));
		else begin
			case ($urandom_range(0, 5))
				0: op = OP_CONT;
				1: op = OP_TEXT;
				2: op = OP_BIN;
				3: op = OP_CLOSE;
				4: op = OP_PING;
				default: op = OP_PONG;
			endcase
		end
		r = $urandom_range(0, 99);
		if (r < 70) len = 64'($urandom_range(0, 12));
		else if (r < 88) len = 64'($urandom_range(13, 40));
		else if (r < 92) len = 64'($urandom_range(126, 200));
		else if (lim_cfg != 32'd0) begin
			// upper word nonzero, so any 32-bit limit rejects it
			hi  = $urandom | 32'd1;
			lo  = $urandom;
			len = {hi, lo};
		end else len = 64'($urandom_range(0, 3));
		queue_frame(op, 1'($urandom_range(0, 1)), $urandom_range(0, 9) < 7,
			$urandom_range(0, 2), len);
	endtask

	// random frames; stray bytes only where a small limit bounds any resync
	task automatic queue_random_run(input int n_bytes, input bit noisy);
		int stop_at;
		logic [7:0] rb;
		stop_at = bytes_queued + n_bytes;
		while (bytes_queued < stop_at) begin
			if (noisy && $urandom_range(0, 19) == 0) begin
				rb = 8'($urandom);
				put_byte(rb);
			end else begin
				queue_random_frame();
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// no limit: bad opcodes, empty frame, masking, close status, all length forms
		set_limit(32'd0);
		@(negedge clk);
		put_byte({1'b1, 3'd0, 4'h3});
		put_byte(8'h7F);
		queue_frame(OP_TEXT, 1'b1, 1'b0, 0, 64'd0);
		queue_frame(OP_BIN, 1'b0, 1'b1, 0, 64'd2);
		queue_frame(OP_CLOSE, 1'b1, 1'b1, 0, 64'd3);
		queue_frame(OP_CLOSE, 1'b1, 1'b0, 0, 64'd1);
		queue_frame(OP_CLOSE, 1'b0, 1'b1, 0, 64'd2);
		queue_frame(OP_PING, 1'b1, 1'b1, 1, 64'd1);
		queue_frame(OP_PONG, 1'b1, 1'b0, 2, 64'd1);
		drain(8);

		// tight limit: over-limit in every length form, close judged after status
		set_limit(32'd3);
		@(negedge clk);
		queue_frame(OP_TEXT, 1'b1, 1'b0, 0, 64'd125);
		queue_frame(OP_BIN, 1'b1, 1'b0, 1, 64'd65535);
		queue_frame(OP_CLOSE, 1'b1, 1'b0, 0, 64'd5);
		queue_frame(OP_CONT, 1'b0, 1'b1, 2, 64'h8000_0000_0000_0000);
		drain(8);

		// widest limit
		set_limit(32'hFFFF_FFFF);
		@(negedge clk);
		queue_frame(OP_BIN, 1'b1, 1'b0, 2, 64'h0000_0001_0000_0000);
		queue_frame(OP_TEXT, 1'b1, 1'b1, 2, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_random_run(60, 1'b0);
		drain(8);

		// long receiver hold while a long frame keeps coming
		set_limit(32'd0);
		@(negedge clk);
		hold_req = hold_req + 1;
		queue_frame(OP_BIN, 1'b1, 1'b1, 0, 64'd60);
		queue_random_run(80, 1'b0);
		drain(8);

		set_limit($urandom_range(1, 30));
		@(negedge clk);
		queue_random_run(80, 1'b1);
		drain(8);

		set_limit(32'd1);
		@(negedge clk);
		queue_random_run(50, 1'b1);
		drain(8);

		// last stretch at full rate
		set_limit($urandom_range(31, 1000));
		@(negedge clk);
		no_idle = 1'b1;
		queue_random_run(70, 1'b1);
		drain(20);

		if (mismatches == 0 && parsed_beats_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (parsed_beats_q.size() != 0)
				$error("%0d expected results never arrived", parsed_beats_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
